/* rtl/fqkr_pkg.sv */
package fqkr_pkg;

    localparam int DATA_W   = 32;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;

    localparam logic [KIND_W-1:0] KIND_ENQ = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DEQ = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DEL = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    // Operation broadcast to every cell of the row in the cycle a request is taken.
    typedef struct packed {
        logic              enq;
        logic              deq;
        logic              del;
        logic [DATA_W-1:0] key;
    } cell_op_t;

endpackage

/* rtl/fifo_queue_with_keyed_removal.sv */
// Bounded FIFO of signed 32-bit values with removal of the first entry equal to a key.
// Input channel s_: s_tuser carries the request kind (enqueue, dequeue, delete by key),
// s_tdata the value to append or the key to look for.
// Result channel m_: exactly one result per request; m_tuser is the status (success,
// empty or not found, full), m_tdata the value taken by a successful dequeue, else zero.
// The entries sit in a row of cells, head in cell 0. All cells compare against the key
// at once, a hit flag ripples down the row, and every cell from the hit onward loads its
// right neighbor, so a request is completed in the cycle that it is taken.
// The result is registered and appears in the cycle after the request is accepted.
// Throughput: one request per cycle while results are read; the compare and hit ripple are combinational.
// The result sits in an output register; a new request is accepted whenever that register
// is empty or is being read in the same cycle, so a stalled receiver holds off input
// after one pending result.
// Reset empties the queue and drops any pending result; slot contents are not cleared,
// only the entry count is.
module fifo_queue_with_keyed_removal
    import fqkr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [DATA_W-1:0]   s_tdata,   // [31:0] value
    input  logic [KIND_W-1:0]   s_tuser,   // [1:0] kind
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [DATA_W-1:0]   m_tdata,   // [31:0] head_value
    output logic [STATUS_W-1:0] m_tuser    // [1:0] status
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                m_valid_reg;
    logic                m_valid_next;
    logic [DATA_W-1:0]   m_data_reg;
    logic [DATA_W-1:0]   m_data_next;
    logic [STATUS_W-1:0] m_status_reg;
    logic [STATUS_W-1:0] m_status_next;

    logic              accept;
    logic              full;
    logic              empty;
    cell_op_t          op;
    logic              hit   [QUEUE_DEPTH+1];
    logic [DATA_W-1:0] data  [QUEUE_DEPTH+1];

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);

    assign op.enq = accept && (s_tuser == KIND_ENQ) && !full;
    assign op.deq = accept && (s_tuser == KIND_DEQ) && !empty;
    assign op.del = accept && (s_tuser == KIND_DEL);
    assign op.key = s_tdata;

    assign hit[0]            = 1'b0;
    assign data[QUEUE_DEPTH] = '0;

    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        fqkr_cell u_cell (
            .aclk      (aclk),
            .op        (op),
            .occupied  (CNT_W'(i) < count_reg),
            .wr_sel    (op.enq && (CNT_W'(i) == count_reg)),
            .hit_in    (hit[i]),
            .next_data (data[i+1]),
            .data_out  (data[i]),
            .hit_out   (hit[i+1])
        );
    end

    always_comb begin
        count_next    = count_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        m_status_next = m_status_reg;
        if (accept) begin
            m_valid_next  = 1'b1;
            m_data_next   = '0;
            m_status_next = ST_MISS;
            case (s_tuser)
                KIND_ENQ: begin
                    if (full) begin
                        m_status_next = ST_FULL;
                    end else begin
                        m_status_next = ST_OK;
                        count_next    = count_reg + CNT_W'(1);
                    end
                end
                KIND_DEQ: begin
                    if (!empty) begin
                        m_status_next = ST_OK;
                        m_data_next   = data[0];
                        count_next    = count_reg - CNT_W'(1);
                    end
                end
                KIND_DEL: begin
                    if (hit[QUEUE_DEPTH]) begin
                        m_status_next = ST_OK;
                        count_next    = count_reg - CNT_W'(1);
                    end
                end
                default: begin
                    m_status_next = ST_MISS;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        m_data_reg   <= m_data_next;
        m_status_reg <= m_status_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    a_full_enq: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tuser == KIND_ENQ && full) |=>
            ($stable(count_reg) && m_tuser == ST_FULL && m_tvalid))
        else $error("enqueue on full queue changed state or missed full status");

    a_deq_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tuser == KIND_DEQ && !empty) |=>
            (count_reg == $past(count_reg) - CNT_W'(1) && m_tuser == ST_OK))
        else $error("dequeue did not remove exactly one entry");

    a_del_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tuser == KIND_DEL && !hit[QUEUE_DEPTH]) |=>
            ($stable(count_reg) && m_tuser == ST_MISS))
        else $error("delete without match changed the queue");

endmodule

/* rtl/fqkr_cell.sv */
module fqkr_cell
    import fqkr_pkg::*;
(
    input  logic              aclk,
    input  cell_op_t          op,
    input  logic              occupied,
    input  logic              wr_sel,
    input  logic              hit_in,
    input  logic [DATA_W-1:0] next_data,
    output logic [DATA_W-1:0] data_out,
    output logic              hit_out
);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic              match_here;
    logic              shift;

    assign match_here = occupied && (data_reg == op.key);
    assign hit_out    = hit_in | match_here;

    // Every cell at or behind the removed entry takes its neighbor's value.
    assign shift = op.deq | (op.del & hit_out);

    always_comb begin
        data_next = data_reg;
        if (wr_sel) begin
            data_next = op.key;
        end else if (shift) begin
            data_next = next_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_out = data_reg;

endmodule
